### sv/mbsb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbsb_pkg
// Shared widths, codes and the result record of the MSB-first bit stream
// buffer.
// ----------------------------------------------------------------------------
package mbsb_pkg;

  localparam int OPCODE_W = 3;
  localparam int WIDTH_W  = 6;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int POS_OUT_W = 13;

  localparam int STORE_BYTES_DEF = 512;
  localparam int MAX_WIDTH_DEF   = 32;

  localparam logic [OPCODE_W-1:0] OP_PUT         = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_GET         = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_ALIGN_WRITE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_ALIGN_READ  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_RESET       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_GET_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [DATA_W-1:0]    value;
    logic [POS_OUT_W-1:0] bits_written;
    logic [POS_OUT_W-1:0] bits_read;
  } result_t;

endpackage : mbsb_pkg
`default_nettype wire

### sv/mbsb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbsb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mbsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule : mbsb_ram
`default_nettype wire

### sv/mbsb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbsb_ctrl
// Request sequencer: checks each request against the bit positions, walks the
// touched bytes through the byte RAM one per cycle, and clears the RAM.
// ----------------------------------------------------------------------------
module mbsb_ctrl
  import mbsb_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire logic [OPCODE_W-1:0]              req_opcode,
  input  wire logic [WIDTH_W-1:0]               req_width,
  input  wire logic [DATA_W-1:0]                req_value,
  input  wire logic                             req_clear,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output result_t                               res,
  output logic                                  ram_we,
  output logic      [$clog2(STORE_BYTES)-1:0]   ram_waddr,
  output logic      [7:0]                       ram_wdata,
  output logic      [$clog2(STORE_BYTES)-1:0]   ram_raddr,
  input  wire logic [7:0]                       ram_rdata
);

  localparam int CAP   = STORE_BYTES * 8;
  localparam int POS_W = $clog2(CAP + 1);
  localparam int AW    = $clog2(STORE_BYTES);
  localparam int VAL_W = (MAX_WIDTH > DATA_W) ? MAX_WIDTH : DATA_W;
  localparam int VX_W  = VAL_W + 16;
  localparam int U_W   = $clog2(MAX_WIDTH + 16);
  localparam int ACC_W = 8 * ((MAX_WIDTH + 14) / 8);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_BYTE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [WIDTH_W:0] MAXW    = (WIDTH_W + 1)'(MAX_WIDTH);
  localparam logic [POS_W:0]   CAP_EXT = (POS_W + 1)'(CAP);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(STORE_BYTES - 1);
  localparam logic [U_W-1:0]   U_BYTE  = U_W'(8);

  logic [1:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic                clr_reply_r, clr_reply_nxt;
  logic [POS_W-1:0]    wp_r, wp_nxt;
  logic [POS_W-1:0]    rp_r, rp_nxt;
  logic                is_put_r, is_put_nxt;
  logic [WIDTH_W-1:0]  w_r, w_nxt;
  logic [VX_W-1:0]     vx_r, vx_nxt;
  logic [U_W-1:0]      u_r, u_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;

  logic                accept;
  logic                put_ok, get_ok;
  logic [POS_W-1:0]    wbyte, rbyte;
  logic [POS_W-1:0]    wp_up, rp_up;
  logic [U_W-1:0]      u_put0, u_get0;
  logic [VX_W-1:0]     vx_sh;
  logic [7:0]          put_mask;
  logic                last_byte;
  logic [ACC_W-1:0]    acc_in;
  logic [ACC_W-1:0]    acc_sh;
  logic [ACC_W-1:0]    w_mask;
  logic [ACC_W+DATA_W-1:0] get_ext;
  logic [POS_W-1:0]    w_pos;

  assign accept    = req_valid && (state_r == S_IDLE);
  assign req_ready = (state_r == S_IDLE);

  assign put_ok = ({1'b0, req_width} <= MAXW) &&
                  (({1'b0, wp_r} + (POS_W + 1)'(req_width)) <= CAP_EXT);
  assign get_ok = (req_width != '0) && ({1'b0, req_width} <= MAXW) &&
                  (({1'b0, rp_r} + (POS_W + 1)'(req_width)) <= {1'b0, wp_r});

  assign wbyte  = wp_r >> 3;
  assign rbyte  = rp_r >> 3;
  assign wp_up  = {wbyte[POS_W-4:0] + (POS_W - 3)'(wp_r[2:0] != 3'd0), 3'b000};
  assign rp_up  = {rbyte[POS_W-4:0] + (POS_W - 3)'(rp_r[2:0] != 3'd0), 3'b000};
  assign u_put0 = U_W'(wp_r[2:0]) + U_W'(req_width);
  assign u_get0 = U_W'(rp_r[2:0]) + U_W'(req_width);
  assign w_pos  = POS_W'(w_r);

  // u counts the request's bits that remain from the start of the current
  // byte; bit t of the byte (LSB is t = 0) carries value bit u - 8 + t.
  assign vx_sh     = vx_r >> u_r;
  assign last_byte = (u_r <= U_BYTE);
  assign acc_in    = {acc_r[ACC_W-9:0], ram_rdata};
  assign acc_sh    = acc_in >> (4'd8 - u_r[3:0]);
  assign w_mask    = ~({ACC_W{1'b1}} << w_r);
  assign get_ext   = {{DATA_W{1'b0}}, acc_sh & w_mask};

  always_comb begin
    logic [U_W:0] ut;
    put_mask = '0;
    for (int t = 0; t < 8; t++) begin
      ut = {1'b0, u_r} + (U_W + 1)'(t);
      put_mask[t] = (ut >= (U_W + 1)'(8)) && (ut < ((U_W + 1)'(w_r) + (U_W + 1)'(8)));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_reply_nxt = clr_reply_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    is_put_nxt    = is_put_r;
    w_nxt         = w_r;
    vx_nxt        = vx_r;
    u_nxt         = u_r;
    addr_nxt      = addr_r;
    acc_nxt       = acc_r;
    status_nxt    = status_r;
    val_nxt       = val_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = (ram_rdata & ~put_mask) | (vx_sh[7:0] & put_mask);

    case (state_r)
      S_CLR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          clr_addr_nxt = '0;
          state_nxt    = clr_reply_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          w_nxt      = req_width;
          vx_nxt     = VX_W'({req_value, 8'h00});
          acc_nxt    = '0;
          status_nxt = ST_OK;
          val_nxt    = '0;
          state_nxt  = S_DONE;
          case (req_opcode)
            OP_PUT: begin
              if (!put_ok) begin
                status_nxt = ST_OVERFLOW;
              end else if (req_width != '0) begin
                is_put_nxt = 1'b1;
                u_nxt      = u_put0;
                addr_nxt   = wbyte[AW-1:0];
                state_nxt  = S_BYTE;
              end
            end
            OP_GET: begin
              if (!get_ok) begin
                status_nxt = ST_GET_FAIL;
              end else begin
                is_put_nxt = 1'b0;
                u_nxt      = u_get0;
                addr_nxt   = rbyte[AW-1:0];
                state_nxt  = S_BYTE;
              end
            end
            OP_ALIGN_WRITE: wp_nxt = wp_up;
            OP_ALIGN_READ:  rp_nxt = rp_up;
            OP_RESET: begin
              wp_nxt = '0;
              rp_nxt = '0;
              if (req_clear) begin
                clr_reply_nxt = 1'b1;
                state_nxt     = S_CLR;
              end
            end
            default: ;
          endcase
        end
      end
      S_BYTE: begin
        // Writes here never hit the byte being fetched for the next step.
        ram_we  = is_put_r;
        acc_nxt = acc_in;
        if (last_byte) begin
          state_nxt = S_DONE;
          if (is_put_r) begin
            wp_nxt = wp_r + w_pos;
          end else begin
            rp_nxt  = rp_r + w_pos;
            val_nxt = get_ext[DATA_W-1:0];
          end
        end else begin
          addr_nxt = addr_r + 1'b1;
          u_nxt    = u_r - U_BYTE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          clr_reply_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ram_raddr = addr_nxt;

  assign res_valid        = (state_r == S_DONE);
  assign res.status       = status_r;
  assign res.value        = val_r;
  assign res.bits_written = POS_OUT_W'({{POS_OUT_W{1'b0}}, wp_r});
  assign res.bits_read    = POS_OUT_W'({{POS_OUT_W{1'b0}}, rp_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      wp_r        <= '0;
      rp_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_reply_r <= clr_reply_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_put_r <= is_put_nxt;
    w_r      <= w_nxt;
    vx_r     <= vx_nxt;
    u_r      <= u_nxt;
    addr_r   <= addr_nxt;
    acc_r    <= acc_nxt;
    status_r <= status_nxt;
    val_r    <= val_nxt;
  end

endmodule : mbsb_ctrl
`default_nettype wire

### sv/msb_first_bit_stream_buffer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bit_stream_buffer_top
// Byte store filled and drained as an MSB-first bit stream, with an output
// register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in_      request    in_valid / in_ready    opcode, width, value_in, clear_store
//  out_     result     out_valid / out_ready  status, value_out, bits_written,
//                                             bits_read
//
// Align, reset without clear, refused and unused requests go straight to a result.
// A put or get of nonzero width walks N = ((position mod 8) + width + 7) / 8
// bytes: a put does one byte RAM read-modify-write per cycle, a get one byte read.
// Reset with clear zeroes the store, one RAM byte per cycle, then gives its result.
// After rst_n a clearing pass over the whole store runs; in_ready stays low.
// A new request is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module msb_first_bit_stream_buffer_top
  import mbsb_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [OPCODE_W-1:0]  in_opcode,
  input  wire logic [WIDTH_W-1:0]   in_width,
  input  wire logic [DATA_W-1:0]    in_value_in,
  input  wire logic                 in_clear_store,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [STATUS_W-1:0]  out_status,
  output logic      [DATA_W-1:0]    out_value_out,
  output logic      [POS_OUT_W-1:0] out_bits_written,
  output logic      [POS_OUT_W-1:0] out_bits_read
);

  localparam int AW = $clog2(STORE_BYTES);

  logic          res_valid;
  logic          res_ready;
  result_t       res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          out_valid_r, out_valid_nxt;
  result_t       out_res_r, out_res_nxt;

  mbsb_ctrl #(
    .STORE_BYTES (STORE_BYTES),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_valid),
    .req_ready  (in_ready),
    .req_opcode (in_opcode),
    .req_width  (in_width),
    .req_value  (in_value_in),
    .req_clear  (in_clear_store),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  mbsb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The output register takes a new result whenever it is empty or drains.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_value_out    = out_res_r.value;
  assign out_bits_written = out_res_r.bits_written;
  assign out_bits_read    = out_res_r.bits_read;

endmodule : msb_first_bit_stream_buffer_top
`default_nettype wire

### tb/sv/mbsb_stream_checker.sv
// ----------------------------------------------------------------------------
// mbsb_stream_checker
// Watches both channels of the MSB-first bit stream buffer. It keeps its own
// shadow of the byte store and the two bit positions, works out the answer to
// every accepted request and compares each accepted result, field by field,
// with the oldest answer still outstanding.
// ----------------------------------------------------------------------------
module mbsb_stream_checker
  import mbsb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic [OPCODE_W-1:0]  in_opcode,
  input  wire logic [WIDTH_W-1:0]   in_width,
  input  wire logic [DATA_W-1:0]    in_value_in,
  input  wire logic                 in_clear_store,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic [STATUS_W-1:0]  out_status,
  input  wire logic [DATA_W-1:0]    out_value_out,
  input  wire logic [POS_OUT_W-1:0] out_bits_written,
  input  wire logic [POS_OUT_W-1:0] out_bits_read,
  output int                        fail_count,
  output int                        pending_count,
  output int                        results_checked,
  output int                        refused_count,
  output int                        overflow_count
);

  localparam int CAPACITY_BITS = STORE_BYTES_DEF * 8;
  localparam int REPORT_LIMIT  = 10;

  logic [7:0]  shadow_bytes [STORE_BYTES_DEF];
  logic [31:0] shadow_wr_pos;
  logic [31:0] shadow_rd_pos;
  result_t     predicted_results [$];
  result_t     want;
  result_t     got;
  int          reported;

  // Applies one request to the shadow state and returns the answer it earns.
  function automatic result_t predict_stream_op(input logic [OPCODE_W-1:0] op,
                                                input logic [WIDTH_W-1:0]  w,
                                                input logic [DATA_W-1:0]   v,
                                                input logic                clr);
    result_t     r;
    int          i;
    logic [31:0] pos;
    logic [DATA_W-1:0] acc;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUT: begin
        if (w > MAX_WIDTH_DEF || shadow_wr_pos + w > CAPACITY_BITS) begin
          r.status = ST_OVERFLOW;
        end else begin
          // Highest of the low w bits goes first.
          for (i = int'(w); i > 0; i--) begin
            pos = shadow_wr_pos;
            shadow_bytes[pos >> 3][7 - (pos & 7)] = v[i-1];
            shadow_wr_pos = shadow_wr_pos + 1;
          end
        end
      end
      OP_GET: begin
        if (w == 0 || w > MAX_WIDTH_DEF || shadow_wr_pos < shadow_rd_pos + w) begin
          r.status = ST_GET_FAIL;
        end else begin
          acc = '0;
          for (i = 0; i < int'(w); i++) begin
            pos = shadow_rd_pos;
            acc = {acc[DATA_W-2:0], shadow_bytes[pos >> 3][7 - (pos & 7)]};
            shadow_rd_pos = shadow_rd_pos + 1;
          end
          r.value = acc;
        end
      end
      OP_ALIGN_WRITE: shadow_wr_pos = (shadow_wr_pos + 7) & ~32'd7;
      OP_ALIGN_READ:  shadow_rd_pos = (shadow_rd_pos + 7) & ~32'd7;
      OP_RESET: begin
        if (clr) begin
          foreach (shadow_bytes[j]) shadow_bytes[j] = 8'h00;
        end
        shadow_wr_pos = '0;
        shadow_rd_pos = '0;
      end
      default: ;
    endcase
    r.bits_written = shadow_wr_pos[POS_OUT_W-1:0];
    r.bits_read    = shadow_rd_pos[POS_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (shadow_bytes[j]) shadow_bytes[j] = 8'h00;
      shadow_wr_pos = '0;
      shadow_rd_pos = '0;
      predicted_results.delete();
      fail_count = 0;
      results_checked = 0;
      refused_count = 0;
      overflow_count = 0;
      reported = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.status       = out_status;
        got.value        = out_value_out;
        got.bits_written = out_bits_written;
        got.bits_read    = out_bits_read;
        results_checked++;
        if (predicted_results.size() == 0) begin
          fail_count++;
          if (reported < REPORT_LIMIT) begin
            reported++;
            $display("unexpected result: status %0d value %h written %0d read %0d",
                     got.status, got.value, got.bits_written, got.bits_read);
          end
        end else begin
          want = predicted_results.pop_front();
          if (got.status !== want.status || got.value !== want.value ||
              got.bits_written !== want.bits_written ||
              got.bits_read !== want.bits_read) begin
            fail_count++;
            if (reported < REPORT_LIMIT) begin
              reported++;
              $display("mismatch on result %0d: expected status %0d value %h written %0d read %0d",
                       results_checked, want.status, want.value, want.bits_written,
                       want.bits_read);
              $display("                        got status %0d value %h written %0d read %0d",
                       got.status, got.value, got.bits_written, got.bits_read);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        want = predict_stream_op(in_opcode, in_width, in_value_in, in_clear_store);
        if (want.status == ST_GET_FAIL) refused_count++;
        if (want.status == ST_OVERFLOW) overflow_count++;
        predicted_results.insert(predicted_results.size(), want);
      end
    end
    pending_count = predicted_results.size();
  end

endmodule : mbsb_stream_checker

### tb/sv/tb_msb_first_bit_stream_buffer_top.sv
// ----------------------------------------------------------------------------
// tb_msb_first_bit_stream_buffer_top
// Drives requests into the MSB-first bit stream buffer and takes its results
// under several idling patterns: a directed opening, a long receiver hold-off,
// a burst that fills the store to overflow, and random traffic over all opcodes.
// The checker beside the block predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_stream_buffer_top;
  import mbsb_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI  = 3'd7;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_LIMIT      = 4000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int PHASE_REQUESTS  = 95;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OPCODE_W-1:0]  in_opcode = OP_PUT;
  logic [WIDTH_W-1:0]   in_width = '0;
  logic [DATA_W-1:0]    in_value_in = '0;
  logic                 in_clear_store = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [DATA_W-1:0]    out_value_out;
  logic [POS_OUT_W-1:0] out_bits_written;
  logic [POS_OUT_W-1:0] out_bits_read;

  int fail_count;
  int pending_count;
  int results_checked;
  int refused_count;
  int overflow_count;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int idle_cycles = 0;
  int n_put = 0;
  int n_get = 0;
  int n_align = 0;
  int n_reset = 0;
  int n_spare = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  msb_first_bit_stream_buffer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_width         (in_width),
    .in_value_in      (in_value_in),
    .in_clear_store   (in_clear_store),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_value_out    (out_value_out),
    .out_bits_written (out_bits_written),
    .out_bits_read    (out_bits_read)
  );

  mbsb_stream_checker stream_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_width         (in_width),
    .in_value_in      (in_value_in),
    .in_clear_store   (in_clear_store),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_value_out    (out_value_out),
    .out_bits_written (out_bits_written),
    .out_bits_read    (out_bits_read),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .results_checked  (results_checked),
    .refused_count    (refused_count),
    .overflow_count   (overflow_count)
  );

  // Offers one request at a falling edge and returns at the falling edge after
  // it was taken, so a following request can reuse the same high valid.
  // Before offering, the sender idles cycle by cycle at the set percentage.
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [WIDTH_W-1:0] w,
                              input logic [DATA_W-1:0] v, input logic clr);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_width       <= w;
    in_value_in    <= v;
    in_clear_store <= clr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      OP_PUT:                        n_put++;
      OP_GET:                        n_get++;
      OP_ALIGN_WRITE, OP_ALIGN_READ: n_align++;
      OP_RESET:                      n_reset++;
      default:                       n_spare++;
    endcase
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic run_random(input int count);
    int                  k;
    int unsigned         pick;
    logic [WIDTH_W-1:0]  w;
    logic                clr;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      // Mostly legal widths, now and then anything the field can hold.
      if ($urandom_range(19) == 0) w = WIDTH_W'($urandom_range(63));
      else                         w = WIDTH_W'($urandom_range(1, 32));
      clr = 1'($urandom_range(1));
      if (pick < 42) begin
        send_request(OP_PUT, w, $urandom, clr);
      end else if (pick < 76) begin
        send_request(OP_GET, w, $urandom, clr);
      end else if (pick < 84) begin
        send_request(OP_ALIGN_WRITE, w, $urandom, clr);
      end else if (pick < 92) begin
        send_request(OP_ALIGN_READ, w, $urandom, clr);
      end else if (pick < 96) begin
        // A clearing reset costs a full pass over the store, so keep it rare.
        send_request(OP_RESET, w, $urandom, $urandom_range(3) == 0);
      end else begin
        case ($urandom_range(2))
          0:       send_request(OP_SPARE_LO, w, $urandom, clr);
          1:       send_request(OP_SPARE_MID, w, $urandom, clr);
          default: send_request(OP_SPARE_HI, w, $urandom, clr);
        endcase
      end
    end
  endtask

  // Receiver: random stalls per cycle, or one long hold-off when asked.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_served++;
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int                 k;
    logic [WIDTH_W-1:0] tail_width;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: width extremes, refusals and alignment corners.
    send_request(OP_RESET, 6'd0, 32'h0000_0000, 1'b1);
    send_request(OP_PUT, 6'd0, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_PUT, 6'd32, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_PUT, 6'd1, 32'h0000_0000, 1'b0);
    send_request(OP_PUT, 6'd7, 32'hAAAA_AA55, 1'b0);
    send_request(OP_PUT, 6'd33, 32'h1234_5678, 1'b0);
    send_request(OP_PUT, 6'd63, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_GET, 6'd0, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_GET, 6'd33, 32'h0000_0000, 1'b0);
    send_request(OP_GET, 6'd1, 32'h0000_0000, 1'b1);
    send_request(OP_GET, 6'd32, 32'h0000_0000, 1'b0);
    send_request(OP_GET, 6'd32, 32'h0000_0000, 1'b0);
    send_request(OP_GET, 6'd7, 32'h0000_0000, 1'b0);
    // Read position jumps past the write position; the next get must fail.
    send_request(OP_PUT, 6'd3, 32'h0000_0005, 1'b0);
    send_request(OP_GET, 6'd2, 32'h0000_0000, 1'b0);
    send_request(OP_ALIGN_READ, 6'd0, 32'h0000_0000, 1'b0);
    send_request(OP_GET, 6'd1, 32'h0000_0000, 1'b0);
    send_request(OP_SPARE_LO, 6'd32, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_SPARE_MID, 6'd1, 32'h0000_0001, 1'b0);
    send_request(OP_SPARE_HI, 6'd63, 32'h8000_0000, 1'b1);
    // Reset without clear, then skip bits by aligning and read the old ones.
    send_request(OP_RESET, 6'd0, 32'h0000_0000, 1'b0);
    send_request(OP_PUT, 6'd3, 32'h0000_0000, 1'b0);
    send_request(OP_ALIGN_WRITE, 6'd0, 32'h0000_0000, 1'b0);
    send_request(OP_GET, 6'd8, 32'h0000_0000, 1'b0);
    drain_results();

    // No idling; the receiver holds off for a long stretch while requests
    // keep coming, so the block backs up and stalls its input.
    hold_requests++;
    run_random(PHASE_REQUESTS);
    drain_results();

    // Fill the store towards the last bit and put past it.
    send_request(OP_RESET, 6'd0, $urandom, 1'b0);
    for (k = 0; k < 127; k++) send_request(OP_PUT, 6'd32, $urandom, 1'b0);
    for (k = 0; k < 8; k++) begin
      tail_width = WIDTH_W'($urandom_range(1, 32));
      send_request(OP_PUT, tail_width, $urandom, 1'b0);
    end
    send_request(OP_ALIGN_WRITE, 6'd0, $urandom, 1'b0);
    send_request(OP_PUT, 6'd1, $urandom, 1'b0);
    for (k = 0; k < 6; k++) send_request(OP_GET, 6'd32, $urandom, 1'b0);
    drain_results();

    sender_idle_pct = 69;
    receiver_stall_pct = 0;
    run_random(PHASE_REQUESTS);
    drain_results();

    sender_idle_pct = 0;
    receiver_stall_pct = 69;
    run_random(PHASE_REQUESTS);
    drain_results();

    sender_idle_pct = 10;
    receiver_stall_pct = 10;
    run_random(PHASE_REQUESTS);
    drain_results();

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d requests: %0d put, %0d get, %0d align, %0d reset, %0d unused opcode.",
             n_put + n_get + n_align + n_reset + n_spare, n_put, n_get, n_align, n_reset,
             n_spare);
    $display("Checked %0d results, %0d refused gets and %0d overflows among them, %0d failed.",
             results_checked, refused_count, overflow_count, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule : tb_msb_first_bit_stream_buffer_top

### filelist.f
sv/mbsb_pkg.sv
sv/mbsb_ram.sv
sv/mbsb_ctrl.sv
sv/msb_first_bit_stream_buffer_top.sv
tb/sv/mbsb_stream_checker.sv
tb/sv/tb_msb_first_bit_stream_buffer_top.sv
